[rtl/sacbu_pkg.sv]
// shared constants, types and decode helpers for the scalar alu, compare and branch unit
`default_nettype none
package sacbu_pkg;

   // default register file depth
   localparam int REG_COUNT_DEF = 64;

   // operation codes
   localparam logic [6:0] ACT_NOP       = 7'd0;
   localparam logic [6:0] ACT_MOVEI     = 7'd1;
   localparam logic [6:0] ACT_MOVELRL   = 7'd2;
   localparam logic [6:0] ACT_MOVELRS   = 7'd3;
   localparam logic [6:0] ACT_MOVEBR    = 7'd4;
   localparam logic [6:0] ACT_ALU_FIRST = 7'd5;
   localparam logic [6:0] ACT_ALU_LAST  = 7'd43;
   localparam logic [6:0] ACT_CMP       = 7'd44;
   localparam logic [6:0] ACT_CMPI      = 7'd45;
   localparam logic [6:0] ACT_BNE       = 7'd46;
   localparam logic [6:0] ACT_BEQ       = 7'd47;
   localparam logic [6:0] ACT_BL        = 7'd48;
   localparam logic [6:0] ACT_BLE       = 7'd49;
   localparam logic [6:0] ACT_BG        = 7'd50;
   localparam logic [6:0] ACT_BGE       = 7'd51;
   localparam logic [6:0] ACT_BLS       = 7'd52;
   localparam logic [6:0] ACT_BLES      = 7'd53;
   localparam logic [6:0] ACT_BGS       = 7'd54;
   localparam logic [6:0] ACT_BGES      = 7'd55;
   localparam logic [6:0] ACT_BRA       = 7'd56;
   localparam logic [6:0] ACT_JMP       = 7'd57;
   localparam logic [6:0] ACT_CALL      = 7'd58;
   localparam logic [6:0] ACT_JMPR      = 7'd59;
   localparam logic [6:0] ACT_CALLR     = 7'd60;
   localparam logic [6:0] ACT_RET       = 7'd61;
   localparam logic [6:0] ACT_SWT       = 7'd62;
   localparam logic [6:0] ACT_ENDP      = 7'd63;

   // alu operation kinds
   localparam logic [3:0] KIND_ADD  = 4'd0;
   localparam logic [3:0] KIND_SUB  = 4'd1;
   localparam logic [3:0] KIND_MULS = 4'd2;
   localparam logic [3:0] KIND_MULU = 4'd3;
   localparam logic [3:0] KIND_DIVS = 4'd4;
   localparam logic [3:0] KIND_DIVU = 4'd5;
   localparam logic [3:0] KIND_AND  = 4'd6;
   localparam logic [3:0] KIND_OR   = 4'd7;
   localparam logic [3:0] KIND_XOR  = 4'd8;
   localparam logic [3:0] KIND_ASL  = 4'd9;
   localparam logic [3:0] KIND_LSL  = 4'd10;
   localparam logic [3:0] KIND_ASR  = 4'd11;
   localparam logic [3:0] KIND_LSR  = 4'd12;

   // operand forms
   localparam logic [1:0] FORM_REG     = 2'd0;
   localparam logic [1:0] FORM_IMM     = 2'd1;
   localparam logic [1:0] FORM_INPLACE = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ILLEGAL = 2'd1;
   localparam logic [1:0] STATUS_END     = 2'd2;
   localparam logic [1:0] STATUS_DIVZERO = 2'd3;

   // flag bit positions
   localparam int FLB_XCHG = 0;
   localparam int FLB_NE   = 1;
   localparam int FLB_SLT  = 2;
   localparam int FLB_ULT  = 3;

   // result size masks by width code
   localparam logic [63:0] SIZE_MASKS [4] = '{
      64'h0000_0000_0000_00FF,
      64'h0000_0000_0000_FFFF,
      64'h0000_0000_FFFF_FFFF,
      64'hFFFF_FFFF_FFFF_FFFF
   };

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_IDX1,
      ST_IDX2,
      ST_READ,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [1:0] form;
   } alu_dec_type;

   // split an alu operation code into kind and operand form
   function automatic alu_dec_type alu_decode(input logic [6:0] act);
      alu_dec_type d;
      case (act) inside
         [7'd5:7'd7]:   d.kind = KIND_ADD;
         [7'd8:7'd10]:  d.kind = KIND_SUB;
         [7'd11:7'd13]: d.kind = KIND_MULS;
         [7'd14:7'd16]: d.kind = KIND_MULU;
         [7'd17:7'd19]: d.kind = KIND_DIVS;
         [7'd20:7'd22]: d.kind = KIND_DIVU;
         [7'd23:7'd25]: d.kind = KIND_AND;
         [7'd26:7'd28]: d.kind = KIND_OR;
         [7'd29:7'd31]: d.kind = KIND_XOR;
         [7'd32:7'd34]: d.kind = KIND_ASL;
         [7'd35:7'd37]: d.kind = KIND_LSL;
         [7'd38:7'd40]: d.kind = KIND_ASR;
         [7'd41:7'd43]: d.kind = KIND_LSR;
         default:       d.kind = KIND_ADD;
      endcase
      d.form = 2'(act - ACT_ALU_FIRST - 7'({3'b000, d.kind} * 7'd3));
      return d;
   endfunction

endpackage
`default_nettype wire

[rtl/sacbu_req_if.sv]
// operation item channel
`default_nettype none
interface sacbu_req_if;
   logic        valid;
   logic        ready;
   logic [6:0]  action;
   logic [1:0]  width_code;
   logic [31:0] first_operand;
   logic [31:0] second_operand;
   logic [5:0]  dest_index;

   modport source (output valid, action, width_code, first_operand, second_operand,
                   dest_index, input ready);
   modport sink (input valid, action, width_code, first_operand, second_operand,
                 dest_index, output ready);
endinterface
`default_nettype wire

[rtl/sacbu_rsp_if.sv]
// result item channel
`default_nettype none
interface sacbu_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        reg_written;
   logic [5:0]  written_index;
   logic [63:0] written_value;
   logic        jump_taken;
   logic [63:0] jump_address;
   logic [3:0]  flags_now;

   modport source (output valid, status, reg_written, written_index, written_value,
                   jump_taken, jump_address, flags_now, input ready);
   modport sink (input valid, status, reg_written, written_index, written_value,
                 jump_taken, jump_address, flags_now, output ready);
endinterface
`default_nettype wire

[rtl/sacbu_regidx.sv]
// two-stage reduction of a 32-bit value modulo the register count
`default_nettype none
module sacbu_regidx #(
   parameter int REG_COUNT = sacbu_pkg::REG_COUNT_DEF
) (
   input  wire logic                         clock,
   input  wire logic [31:0]                  value,
   output      logic [$clog2(REG_COUNT)-1:0] index
);
   localparam int IDX_W = $clog2(REG_COUNT);
   localparam int SHIFT = 32 + IDX_W;
   localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) / 64'(REG_COUNT)) + 64'd1;
   localparam logic [33:0] RECIP = RECIP_FULL[33:0];

   logic [65:0]      prod_ff, prod_in;
   logic [31:0]      value_ff, value_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [31:0]      quot;
   logic [31:0]      rem_full;

   // stage one: multiply by the reciprocal
   assign prod_in  = 66'(value) * 66'(RECIP);
   assign value_in = value;

   // stage two: quotient back-multiplied and subtracted
   always_comb begin
      quot     = 32'(prod_ff >> SHIFT);
      rem_full = value_ff - 32'(quot * 32'(REG_COUNT));
      index_in = rem_full[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      value_ff <= value_in;
      index_ff <= index_in;
   end

   assign index = index_ff;
endmodule
`default_nettype wire

[rtl/sacbu_regfile.sv]
// register file memory, one write and two registered reads, with per-entry valid bits
`default_nettype none
module sacbu_regfile #(
   parameter int REG_COUNT = sacbu_pkg::REG_COUNT_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         we,
   input  wire logic [$clog2(REG_COUNT)-1:0] waddr,
   input  wire logic [63:0]                  wdata,
   input  wire logic [$clog2(REG_COUNT)-1:0] raddr_a,
   input  wire logic [$clog2(REG_COUNT)-1:0] raddr_b,
   output      logic [63:0]                  rdata_a,
   output      logic [63:0]                  rdata_b
);
   logic [63:0]          mem [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff, valid_in;
   logic [63:0]          data_a_ff, data_b_ff;
   logic                 vld_a_ff, vld_b_ff;

   // entries never written read as zero
   always_comb begin
      valid_in = valid_ff;
      if (we) begin
         valid_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // memory write and registered reads
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      data_a_ff <= mem[raddr_a];
      data_b_ff <= mem[raddr_b];
      vld_a_ff  <= valid_ff[raddr_a];
      vld_b_ff  <= valid_ff[raddr_b];
   end

   assign rdata_a = vld_a_ff ? data_a_ff : 64'd0;
   assign rdata_b = vld_b_ff ? data_b_ff : 64'd0;
endmodule
`default_nettype wire

[rtl/sacbu_divider.sv]
// unsigned 64-bit restoring divider, one quotient bit per cycle
`default_nettype none
module sacbu_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output      logic        done,
   output      logic [63:0] quotient
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [65:0] trial;

   // one trial subtraction per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {1'b0, rem_ff, quo_ff[63]} - {2'b00, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[65]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

[rtl/scalar_alu_compare_branch_unit.sv]
// top level: sequencer, alu, compare and branch logic around the register file memory
// an item passes the index, read, execute and done states to a valid result; multiplies
// add a multiply state, divides a divide state (one quotient bit per cycle in the divider)
// one item is in work at a time: the next item is accepted the cycle after the result
// is registered
// reset is synchronous: register file reads as zero, flags, link and branch registers clear
`default_nettype none
module scalar_alu_compare_branch_unit #(
   parameter int REG_COUNT = sacbu_pkg::REG_COUNT_DEF
) (
   input wire logic clock,
   input wire logic reset,
   sacbu_req_if.sink   req_chan,
   sacbu_rsp_if.source rsp_chan
);
   localparam int IDX_W = $clog2(REG_COUNT);

   sacbu_pkg::state_type state_ff, state_in;

   // latched item fields
   logic [6:0]  act_ff, act_in;
   logic [1:0]  wcode_ff, wcode_in;
   logic [31:0] op0_ff, op0_in;
   logic [31:0] op1_ff, op1_in;
   logic [5:0]  dsti_ff, dsti_in;

   // architectural state outside the memory
   logic [3:0]  flag_ff, flag_in;
   logic [63:0] link_ff, link_in;
   logic [63:0] branch_ff, branch_in;

   // pending result
   logic [1:0]  res_status_ff, res_status_in;
   logic        res_wr_ff, res_wr_in;
   logic [63:0] res_wval_ff, res_wval_in;
   logic        res_jmp_ff, res_jmp_in;
   logic [63:0] res_jaddr_ff, res_jaddr_in;

   // multiply partial products and divide sign
   logic [63:0] pp_ll_ff, pp_ll_in;
   logic [63:0] pp_lh_ff, pp_lh_in;
   logic [63:0] pp_hl_ff, pp_hl_in;
   logic        div_neg_ff, div_neg_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic        out_wr_ff, out_wr_in;
   logic [5:0]  out_widx_ff, out_widx_in;
   logic [63:0] out_wval_ff, out_wval_in;
   logic        out_jmp_ff, out_jmp_in;
   logic [63:0] out_jaddr_ff, out_jaddr_in;
   logic [3:0]  out_flags_ff, out_flags_in;

   logic [IDX_W-1:0] idx0, idx1, idxd, raddr_a;
   logic [63:0]      rf_a, rf_b;
   logic             rf_we;

   logic                  div_start, div_done;
   logic [63:0]           div_dvd, div_dvs, div_quo, div_res;
   sacbu_pkg::alu_dec_type dec;
   logic                  is_alu;
   logic [63:0]           mask, op0_ext, a_val, b_val, alu_r;
   logic [63:0]           cmp_left, cmp_right, mul_sum;
   logic                  take, fl_ne, fl_sl, fl_ul, big_shift;

   // register index reduction for both sources and the destination
   sacbu_regidx #(.REG_COUNT(REG_COUNT)) u_idx0 (
      .clock(clock), .value(op0_ff), .index(idx0)
   );
   sacbu_regidx #(.REG_COUNT(REG_COUNT)) u_idx1 (
      .clock(clock), .value(op1_ff), .index(idx1)
   );
   sacbu_regidx #(.REG_COUNT(REG_COUNT)) u_idxd (
      .clock(clock), .value({26'd0, dsti_ff}), .index(idxd)
   );

   sacbu_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
      .clock(clock), .reset(reset),
      .we(rf_we), .waddr(idxd), .wdata(res_wval_ff),
      .raddr_a(raddr_a), .raddr_b(idx0),
      .rdata_a(rf_a), .rdata_b(rf_b)
   );

   sacbu_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_dvd), .divisor(div_dvs),
      .done(div_done), .quotient(div_quo)
   );

   // decode and operand selection
   always_comb begin
      dec     = sacbu_pkg::alu_decode(act_ff);
      is_alu  = act_ff inside {[sacbu_pkg::ACT_ALU_FIRST:sacbu_pkg::ACT_ALU_LAST]};
      mask    = sacbu_pkg::SIZE_MASKS[wcode_ff];
      op0_ext = {32'd0, op0_ff};
      raddr_a = (is_alu && dec.form == sacbu_pkg::FORM_INPLACE) ? idxd : idx1;
      a_val   = rf_a;
      b_val   = (dec.form == sacbu_pkg::FORM_REG) ? rf_b : op0_ext;
      fl_ne   = flag_ff[sacbu_pkg::FLB_NE];
      fl_sl   = flag_ff[sacbu_pkg::FLB_SLT];
      fl_ul   = flag_ff[sacbu_pkg::FLB_ULT];
   end

   // combinational alu results for the kinds other than multiply and divide
   always_comb begin
      big_shift = |b_val[63:6];
      case (dec.kind)
         sacbu_pkg::KIND_ADD: alu_r = a_val + b_val;
         sacbu_pkg::KIND_SUB: alu_r = a_val - b_val;
         sacbu_pkg::KIND_AND: alu_r = a_val & b_val;
         sacbu_pkg::KIND_OR:  alu_r = a_val | b_val;
         sacbu_pkg::KIND_XOR: alu_r = a_val ^ b_val;
         sacbu_pkg::KIND_ASL,
         sacbu_pkg::KIND_LSL: alu_r = big_shift ? 64'd0 : (a_val << b_val[5:0]);
         sacbu_pkg::KIND_ASR: alu_r = big_shift ? {64{a_val[63]}}
                                                : 64'($signed(a_val) >>> b_val[5:0]);
         sacbu_pkg::KIND_LSR: alu_r = big_shift ? 64'd0 : (a_val >> b_val[5:0]);
         default:             alu_r = 64'd0;
      endcase
   end

   // compare operands, branch condition, multiply and divide finishing
   always_comb begin
      cmp_left  = rf_a & mask;
      cmp_right = ((act_ff == sacbu_pkg::ACT_CMP) ? rf_b : op0_ext) & mask;
      case (act_ff)
         sacbu_pkg::ACT_BNE:  take = fl_ne;
         sacbu_pkg::ACT_BEQ:  take = !fl_ne;
         sacbu_pkg::ACT_BL:   take = fl_ul;
         sacbu_pkg::ACT_BLE:  take = fl_ul || !fl_ne;
         sacbu_pkg::ACT_BG:   take = !fl_ul && fl_ne;
         sacbu_pkg::ACT_BGE:  take = !fl_ul || !fl_ne;
         sacbu_pkg::ACT_BLS:  take = fl_sl;
         sacbu_pkg::ACT_BLES: take = fl_sl || !fl_ne;
         sacbu_pkg::ACT_BGS:  take = !fl_sl && fl_ne;
         default:             take = !fl_sl || !fl_ne;
      endcase
      mul_sum = pp_ll_ff + {pp_lh_ff[31:0] + pp_hl_ff[31:0], 32'd0};
      div_res = div_neg_ff ? (64'd0 - div_quo) : div_quo;
      if (dec.kind == sacbu_pkg::KIND_DIVS) begin
         div_dvd = a_val[63] ? (64'd0 - a_val) : a_val;
         div_dvs = b_val[63] ? (64'd0 - b_val) : b_val;
      end else begin
         div_dvd = a_val;
         div_dvs = b_val;
      end
   end

   // sequencer and next state
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      wcode_in      = wcode_ff;
      op0_in        = op0_ff;
      op1_in        = op1_ff;
      dsti_in       = dsti_ff;
      flag_in       = flag_ff;
      link_in       = link_ff;
      branch_in     = branch_ff;
      res_status_in = res_status_ff;
      res_wr_in     = res_wr_ff;
      res_wval_in   = res_wval_ff;
      res_jmp_in    = res_jmp_ff;
      res_jaddr_in  = res_jaddr_ff;
      pp_ll_in      = pp_ll_ff;
      pp_lh_in      = pp_lh_ff;
      pp_hl_in      = pp_hl_ff;
      div_neg_in    = div_neg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_status_in = out_status_ff;
      out_wr_in     = out_wr_ff;
      out_widx_in   = out_widx_ff;
      out_wval_in   = out_wval_ff;
      out_jmp_in    = out_jmp_ff;
      out_jaddr_in  = out_jaddr_ff;
      out_flags_in  = out_flags_ff;
      div_start     = 1'b0;
      rf_we         = 1'b0;

      case (state_ff)
         sacbu_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               act_in   = req_chan.action;
               wcode_in = req_chan.width_code;
               op0_in   = req_chan.first_operand;
               op1_in   = req_chan.second_operand;
               dsti_in  = req_chan.dest_index;
               state_in = sacbu_pkg::ST_IDX1;
            end
         end
         sacbu_pkg::ST_IDX1: state_in = sacbu_pkg::ST_IDX2;
         sacbu_pkg::ST_IDX2: state_in = sacbu_pkg::ST_READ;
         sacbu_pkg::ST_READ: state_in = sacbu_pkg::ST_EXEC;
         sacbu_pkg::ST_EXEC: begin
            res_status_in = sacbu_pkg::STATUS_OK;
            res_wr_in     = 1'b0;
            res_wval_in   = 64'd0;
            res_jmp_in    = 1'b0;
            res_jaddr_in  = 64'd0;
            state_in      = sacbu_pkg::ST_DONE;
            if (act_ff == sacbu_pkg::ACT_NOP) begin
               res_wr_in = 1'b0;
            end else if (act_ff == sacbu_pkg::ACT_MOVEI) begin
               res_wr_in   = 1'b1;
               res_wval_in = op0_ext;
            end else if (act_ff == sacbu_pkg::ACT_MOVELRL) begin
               res_wr_in   = 1'b1;
               res_wval_in = link_ff;
            end else if (act_ff == sacbu_pkg::ACT_MOVELRS) begin
               link_in = rf_b;
            end else if (act_ff == sacbu_pkg::ACT_MOVEBR) begin
               branch_in = rf_b;
            end else if (is_alu) begin
               if (dec.kind == sacbu_pkg::KIND_MULS || dec.kind == sacbu_pkg::KIND_MULU) begin
                  pp_ll_in = 64'(a_val[31:0]) * 64'(b_val[31:0]);
                  pp_lh_in = 64'(a_val[31:0]) * 64'(b_val[63:32]);
                  pp_hl_in = 64'(a_val[63:32]) * 64'(b_val[31:0]);
                  state_in = sacbu_pkg::ST_MUL;
               end else if (dec.kind == sacbu_pkg::KIND_DIVS ||
                            dec.kind == sacbu_pkg::KIND_DIVU) begin
                  if (b_val == 64'd0) begin
                     res_status_in = sacbu_pkg::STATUS_DIVZERO;
                  end else begin
                     div_start  = 1'b1;
                     div_neg_in = (dec.kind == sacbu_pkg::KIND_DIVS) &&
                                  (a_val[63] != b_val[63]);
                     state_in   = sacbu_pkg::ST_DIV;
                  end
               end else begin
                  res_wr_in   = 1'b1;
                  res_wval_in = alu_r & mask;
               end
            end else if (act_ff == sacbu_pkg::ACT_CMP || act_ff == sacbu_pkg::ACT_CMPI) begin
               flag_in[sacbu_pkg::FLB_NE]  = cmp_left != cmp_right;
               flag_in[sacbu_pkg::FLB_SLT] = $signed(cmp_left) < $signed(cmp_right);
               flag_in[sacbu_pkg::FLB_ULT] = cmp_left < cmp_right;
            end else if (act_ff inside {[sacbu_pkg::ACT_BNE:sacbu_pkg::ACT_BGES]}) begin
               res_jmp_in   = take;
               res_jaddr_in = take ? op0_ext : 64'd0;
               flag_in      = {3'b000, flag_ff[sacbu_pkg::FLB_XCHG]};
            end else if (act_ff inside {sacbu_pkg::ACT_BRA, sacbu_pkg::ACT_JMP,
                                        sacbu_pkg::ACT_JMPR}) begin
               res_jmp_in   = 1'b1;
               res_jaddr_in = op0_ext;
            end else if (act_ff == sacbu_pkg::ACT_CALL || act_ff == sacbu_pkg::ACT_CALLR) begin
               res_jmp_in   = 1'b1;
               res_jaddr_in = op0_ext;
               link_in      = {32'd0, op1_ff};
            end else if (act_ff == sacbu_pkg::ACT_RET) begin
               res_jmp_in   = 1'b1;
               res_jaddr_in = link_ff;
            end else if (act_ff == sacbu_pkg::ACT_SWT) begin
               flag_in = {flag_ff[3:1] | op0_ff[3:1], op0_ff[0]};
            end else if (act_ff == sacbu_pkg::ACT_ENDP) begin
               res_status_in = sacbu_pkg::STATUS_END;
            end else begin
               res_status_in = sacbu_pkg::STATUS_ILLEGAL;
            end
         end
         sacbu_pkg::ST_MUL: begin
            res_wr_in   = 1'b1;
            res_wval_in = mul_sum & mask;
            state_in    = sacbu_pkg::ST_DONE;
         end
         sacbu_pkg::ST_DIV: begin
            if (div_done) begin
               res_wr_in   = 1'b1;
               res_wval_in = div_res & mask;
               state_in    = sacbu_pkg::ST_DONE;
            end
         end
         sacbu_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_wr_in     = res_wr_ff;
               out_widx_in   = res_wr_ff ? 6'(idxd) : 6'd0;
               out_wval_in   = res_wval_ff;
               out_jmp_in    = res_jmp_ff;
               out_jaddr_in  = res_jaddr_ff;
               out_flags_in  = flag_ff;
               rf_we         = res_wr_ff;
               state_in      = sacbu_pkg::ST_IDLE;
            end
         end
         default: state_in = sacbu_pkg::ST_IDLE;
      endcase
   end

   // control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sacbu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         flag_ff      <= '0;
         link_ff      <= '0;
         branch_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         flag_ff      <= flag_in;
         link_ff      <= link_in;
         branch_ff    <= branch_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      wcode_ff      <= wcode_in;
      op0_ff        <= op0_in;
      op1_ff        <= op1_in;
      dsti_ff       <= dsti_in;
      res_status_ff <= res_status_in;
      res_wr_ff     <= res_wr_in;
      res_wval_ff   <= res_wval_in;
      res_jmp_ff    <= res_jmp_in;
      res_jaddr_ff  <= res_jaddr_in;
      pp_ll_ff      <= pp_ll_in;
      pp_lh_ff      <= pp_lh_in;
      pp_hl_ff      <= pp_hl_in;
      div_neg_ff    <= div_neg_in;
      out_status_ff <= out_status_in;
      out_wr_ff     <= out_wr_in;
      out_widx_ff   <= out_widx_in;
      out_wval_ff   <= out_wval_in;
      out_jmp_ff    <= out_jmp_in;
      out_jaddr_ff  <= out_jaddr_in;
      out_flags_ff  <= out_flags_in;
   end

   // channel drive
   assign req_chan.ready         = (state_ff == sacbu_pkg::ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = out_status_ff;
   assign rsp_chan.reg_written   = out_wr_ff;
   assign rsp_chan.written_index = out_widx_ff;
   assign rsp_chan.written_value = out_wval_ff;
   assign rsp_chan.jump_taken    = out_jmp_ff;
   assign rsp_chan.jump_address  = out_jaddr_ff;
   assign rsp_chan.flags_now     = out_flags_ff;
endmodule
`default_nettype wire

[rtl/sacbu_checker.sv]
// port-level checks for the scalar alu, compare and branch unit, bound to the top level
`default_nettype none
module sacbu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  status,
   input wire logic        reg_written,
   input wire logic [5:0]  written_index,
   input wire logic [63:0] written_value,
   input wire logic        jump_taken,
   input wire logic [63:0] jump_address
);
   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in work");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(written_value) && $stable(status))
      else $error("stalled result changed");

   // error status means no write and no jump
   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != sacbu_pkg::STATUS_OK |-> !reg_written && !jump_taken)
      else $error("error result with side effect");

   // unused result fields read zero
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (reg_written || (written_value == 64'd0 && written_index == 6'd0)) &&
                    (jump_taken || jump_address == 64'd0))
      else $error("unused result field not zero");
endmodule

bind scalar_alu_compare_branch_unit sacbu_checker u_sacbu_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .status(rsp_chan.status),
   .reg_written(rsp_chan.reg_written),
   .written_index(rsp_chan.written_index),
   .written_value(rsp_chan.written_value),
   .jump_taken(rsp_chan.jump_taken),
   .jump_address(rsp_chan.jump_address)
);
`default_nettype wire
